// ===== src/modular_exponentiation_core_defines.svh =====
// ----------------------------------------------------------------------------
// modular exponentiation core assertion macros
// shared assertion forms for the modules of the core
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// checked at every edge outside reset
`define MEXP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MEXP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package mexp_pkg;

    localparam int MEXP_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int IN_DATA_W      = 3 * FIELD_W;
    localparam int OUT_DATA_W     = FIELD_W;

    typedef enum logic [1:0] {
        OP_REDUCE = 2'd0,
        OP_ACC    = 2'd1,
        OP_SQUARE = 2'd2
    } t_opsel;

    typedef struct packed {
        logic   load;
        logic   mul_start;
        t_opsel sel;
        logic   wr_acc;
        logic   wr_base;
        logic   shift_exp;
        logic   out_load;
    } t_cmd;

    typedef struct packed {
        logic mod_small;
        logic exp_zero;
        logic exp_lsb;
        logic mul_busy;
        logic mul_done;
    } t_status;

endpackage

// ===== src/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mexp_mulmod
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
`include "modular_exponentiation_core_defines.svh"

module mexp_mulmod #(
    parameter int WIDTH = mexp_pkg::MEXP_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    input  logic [WIDTH-1:0] i_mod,
    output logic [WIDTH-1:0] o_prod,
    output logic             o_busy,
    output logic             o_done
);
    import mexp_pkg::*;

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [WIDTH-1:0] r_p, n_p;
    logic [WIDTH-1:0] r_x, n_x;
    logic [WIDTH-1:0] r_y, n_y;

    logic [WIDTH:0]   dbl, dbl_sub, sum, sum_sub, mod_ext;
    logic [WIDTH-1:0] dbl_red, addend, step_val;

    // p = (2p + bit * x) mod m, done as two reductions
    always_comb begin
        mod_ext  = {1'b0, i_mod};
        dbl      = {r_p, 1'b0};
        dbl_sub  = dbl - mod_ext;
        dbl_red  = (dbl >= mod_ext) ? dbl_sub[WIDTH-1:0] : dbl[WIDTH-1:0];
        addend   = r_y[WIDTH-1] ? r_x : '0;
        sum      = {1'b0, dbl_red} + {1'b0, addend};
        sum_sub  = sum - mod_ext;
        step_val = (sum >= mod_ext) ? sum_sub[WIDTH-1:0] : sum[WIDTH-1:0];
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_p    = r_p;
        n_x    = r_x;
        n_y    = r_y;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(WIDTH - 1);
            n_p    = '0;
            n_x    = i_x;
            n_y    = i_y;
        end else if (r_busy) begin
            n_p = step_val;
            n_y = {r_y[WIDTH-2:0], 1'b0};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_p   <= n_p;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_prod = r_p;
    assign o_busy = r_busy;
    assign o_done = r_done;

    `MEXP_ASSERT(a_partial_below_mod, r_busy |-> (r_p < i_mod), "partial product not reduced")
    `MEXP_ASSERT(a_start_runs, i_start |=> (r_busy && !r_done), "start did not launch product")
    `MEXP_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (!r_busy && !r_done), "busy after reset")

endmodule

// ===== src/mexp_datapath.sv =====
// ----------------------------------------------------------------------------
// mexp_datapath
// operand registers, shared modular multiplier and result register
// ----------------------------------------------------------------------------
module mexp_datapath #(
    parameter int WIDTH = mexp_pkg::MEXP_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mexp_pkg::t_cmd                  i_cmd,
    input  logic [mexp_pkg::IN_DATA_W-1:0]  i_in_data,
    output mexp_pkg::t_status               o_status,
    output logic [mexp_pkg::OUT_DATA_W-1:0] o_out_data
);
    import mexp_pkg::*;

    logic [WIDTH-1:0] r_acc, n_acc;
    logic [WIDTH-1:0] r_base, n_base;
    logic [WIDTH-1:0] r_exp, n_exp;
    logic [WIDTH-1:0] r_mod, n_mod;
    logic [WIDTH-1:0] r_out, n_out;

    logic [WIDTH-1:0] mul_x, mul_prod;
    logic             mul_busy, mul_done;

    always_comb begin
        case (i_cmd.sel)
            OP_REDUCE: mul_x = WIDTH'(1);
            OP_ACC:    mul_x = r_acc;
            OP_SQUARE: mul_x = r_base;
            default:   mul_x = r_base;
        endcase
    end

    mexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_x     (mul_x),
        .i_y     (r_base),
        .i_mod   (r_mod),
        .o_prod  (mul_prod),
        .o_busy  (mul_busy),
        .o_done  (mul_done)
    );

    always_comb begin
        n_acc  = r_acc;
        n_base = r_base;
        n_exp  = r_exp;
        n_mod  = r_mod;
        n_out  = r_out;
        if (i_cmd.load) begin
            n_acc  = WIDTH'(1);
            n_base = WIDTH'(i_in_data[FIELD_W-1:0]);
            n_exp  = WIDTH'(i_in_data[2*FIELD_W-1:FIELD_W]);
            n_mod  = WIDTH'(i_in_data[3*FIELD_W-1:2*FIELD_W]);
        end
        if (i_cmd.wr_acc) begin
            n_acc = mul_prod;
        end
        if (i_cmd.wr_base) begin
            n_base = mul_prod;
        end
        if (i_cmd.shift_exp) begin
            n_exp = r_exp >> 1;
        end
        if (i_cmd.out_load) begin
            n_out = o_status.mod_small ? '0 : r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_base <= n_base;
        r_exp  <= n_exp;
        r_mod  <= n_mod;
        r_out  <= n_out;
    end

    always_comb begin
        o_status.mod_small = (r_mod < WIDTH'(2));
        o_status.exp_zero  = (r_exp == '0);
        o_status.exp_lsb   = r_exp[0];
        o_status.mul_busy  = mul_busy;
        o_status.mul_done  = mul_done;
    end

    assign o_out_data = OUT_DATA_W'(r_out);

endmodule

// ===== src/mexp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mexp_ctrl
// square-and-multiply sequencer and output handshake
// ----------------------------------------------------------------------------
`include "modular_exponentiation_core_defines.svh"

module mexp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  mexp_pkg::t_status i_status,
    output mexp_pkg::t_cmd    o_cmd
);
    import mexp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_START  = 6'b000010,
        S_REDUCE = 6'b000100,
        S_CHECK  = 6'b001000,
        S_MULACC = 6'b010000,
        S_SQUARE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_finish, n_finish;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state  = r_state;
        n_finish = r_finish;
        o_cmd.load      = 1'b0;
        o_cmd.mul_start = 1'b0;
        o_cmd.sel       = OP_REDUCE;
        o_cmd.wr_acc    = 1'b0;
        o_cmd.wr_base   = 1'b0;
        o_cmd.shift_exp = 1'b0;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (r_finish) begin
                    if (!r_out_valid || i_out_ready) begin
                        o_cmd.out_load = 1'b1;
                        n_finish       = 1'b0;
                    end
                end else if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_status.mod_small) begin
                    n_finish = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.sel       = OP_REDUCE;
                    n_state         = S_REDUCE;
                end
            end
            S_REDUCE: begin
                if (i_status.mul_done) begin
                    o_cmd.wr_base = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.exp_zero) begin
                    n_finish = 1'b1;
                    n_state  = S_IDLE;
                end else if (i_status.exp_lsb) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.sel       = OP_ACC;
                    n_state         = S_MULACC;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.sel       = OP_SQUARE;
                    n_state         = S_SQUARE;
                end
            end
            S_MULACC: begin
                if (i_status.mul_done) begin
                    o_cmd.wr_acc    = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.sel       = OP_SQUARE;
                    n_state         = S_SQUARE;
                end
            end
            S_SQUARE: begin
                if (i_status.mul_done) begin
                    o_cmd.wr_base   = 1'b1;
                    o_cmd.shift_exp = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result register may still hold the previous result while a new item runs
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_finish    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_finish    <= n_finish;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_finish;
    assign o_out_valid = r_out_valid;

    `MEXP_ASSERT(a_accept_starts, (i_in_valid && o_in_ready) |=> (r_state == S_START), "accepted transfer did not start")
    `MEXP_ASSERT(a_start_when_free, o_cmd.mul_start |-> !i_status.mul_busy, "multiplier started while busy")
    `MEXP_ASSERT(a_load_shows, o_cmd.out_load |=> r_out_valid, "result not presented after load")

endmodule

// ===== src/modular_exponentiation_core.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// base to the power exponent modulo modulus, right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// One item at a time: a transfer on s_axis carries base, exponent and modulus,
// and one result leaves on m_axis. All products run on a single bit-serial
// modular multiplier. The base is first reduced modulo the modulus (one
// product), then each exponent bit up to the highest set bit costs one square
// plus one multiply where the bit is one, with one decision in S_CHECK per
// bit. A modulus below two skips the products and gives a zero result. The
// next item is accepted as soon as the previous result is in the output register.
// ----------------------------------------------------------------------------
module modular_exponentiation_core #(
    parameter int WIDTH = mexp_pkg::MEXP_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // base_value, exponent_value, modulus_value
    input  logic [mexp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // power_result
    output logic [mexp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import mexp_pkg::*;

    t_cmd    cmd;
    t_status status;

    mexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mexp_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (s_axis_tdata),
        .o_status   (status),
        .o_out_data (m_axis_tdata)
    );

endmodule

// ===== tb/modexp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_checker
// watches both stream channels of the modular exponentiation core, predicts
// base^exponent mod modulus for every input transfer and compares each output
// transfer in order with the oldest prediction
// ----------------------------------------------------------------------------
module modexp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    // base_value, exponent_value, modulus_value
    input  logic [mexp_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // power_result
    input  logic [mexp_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,
    output int                              o_fail_count,
    output int                              o_pending
);
    import mexp_pkg::*;

    logic [FIELD_W-1:0] power_expected[$];
    logic [FIELD_W-1:0] power_wanted;
    int                 fail_total = 0;
    int                 pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    function automatic logic [FIELD_W-1:0] predict_power(
        input logic [FIELD_W-1:0] base_value,
        input logic [FIELD_W-1:0] exponent_value,
        input logic [FIELD_W-1:0] modulus_value
    );
        logic [63:0]        modulus;
        logic [63:0]        product;
        logic [63:0]        square;
        logic [FIELD_W-1:0] bits_left;
        modulus   = {32'd0, modulus_value};
        bits_left = exponent_value;
        if (modulus < 64'd2) begin
            return '0;
        end
        product = 64'd1;
        square  = {32'd0, base_value} % modulus;
        while (bits_left != '0) begin
            if (bits_left[0]) begin
                product = (product * square) % modulus;
            end
            square    = (square * square) % modulus;
            bits_left = bits_left >> 1;
        end
        return product[FIELD_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] wanted,
                                   input logic [FIELD_W-1:0] seen);
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, wanted, seen);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                power_expected.push_back(predict_power(i_s_axis_tdata[FIELD_W-1:0],
                                                       i_s_axis_tdata[2*FIELD_W-1:FIELD_W],
                                                       i_s_axis_tdata[3*FIELD_W-1:2*FIELD_W]));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (power_expected.size() == 0) begin
                    report_mismatch("unexpected power_result", '0, i_m_axis_tdata);
                end else begin
                    power_wanted = power_expected.pop_front();
                    if (i_m_axis_tdata !== power_wanted) begin
                        report_mismatch("power_result", power_wanted, i_m_axis_tdata);
                    end
                end
            end
        end
        pending_total = power_expected.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// regression of the modular exponentiation core: directed corner jobs, then
// random jobs with random stalls on both channels; a separate checker
// predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
    import mexp_pkg::*;

    localparam int RANDOM_JOBS = 273;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 64;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // base_value, exponent_value, modulus_value
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // power_result
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int   fail_count;
    int   pending_count;
    int   quiet_cycles = 0;
    logic calm = 1'b0;

    modular_exponentiation_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    modexp_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    initial begin
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 31);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("modular_exponentiation_core regression: fail");
                $finish;
            end
        end
    end

    task automatic send_power_job(input logic [31:0] base_value,
                                  input logic [31:0] exponent_value,
                                  input logic [31:0] modulus_value);
        while (!calm && $urandom_range(0, 99) < 31) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {modulus_value, exponent_value, base_value};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    function automatic logic [31:0] pick_modulus();
        case ($urandom_range(0, 19))
            0:       return $urandom_range(0, 1);
            1, 2, 3: return $urandom_range(2, 255);
            4:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom | 32'h0000_0002;
        endcase
    endfunction

    function automatic logic [31:0] pick_exponent();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 3);
            default: return $urandom >> $urandom_range(8, 31);
        endcase
    endfunction

    function automatic logic [31:0] pick_base();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corners: zero and full fields, degenerate moduli, reduced base
        send_power_job(32'd0,          32'd0,          32'd2);
        send_power_job(32'd0,          32'd5,          32'd7);
        send_power_job(32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_power_job(32'hFFFF_FFFF,  32'd1,          32'hFFFF_FFFE);
        send_power_job(32'd3,          32'd0,          32'd1);
        send_power_job(32'd3,          32'd0,          32'd0);
        send_power_job(32'd12345,      32'd678,        32'd0);
        send_power_job(32'd12345,      32'd678,        32'd1);
        send_power_job(32'd100,        32'd3,          32'd7);
        send_power_job(32'd2,          32'hFFFF_FFFF,  32'hFFFF_FFFB);
        send_power_job(32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd2);
        send_power_job(32'd7,          32'd0,          32'hFFFF_FFFF);
        send_power_job(32'hFFFF_FFFE,  32'd2,          32'hFFFF_FFFF);
        send_power_job(32'h8000_0000,  32'h8000_0000,  32'h8000_0001);
        send_power_job(32'd5,          32'd1,          32'd3);
        send_power_job(32'd1,          32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_power_job(32'hDEAD_BEEF,  32'h1234_5678,  32'hFFFF_FFC5);

        for (int n = 0; n < RANDOM_JOBS; n++) begin
            calm = (n >= 120 && n < 170);
            send_power_job(pick_base(), pick_exponent(), pick_modulus());
        end
        calm = 1'b0;

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("modular_exponentiation_core regression: pass");
        end else begin
            $display("modular_exponentiation_core regression: fail");
        end
        $finish;
    end

endmodule
